// ----- rtl/mpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpfd_pkg
// shared types and codes for the page-mode framebuffer drawing engine
// ----------------------------------------------------------------------------
package mpfd_pkg;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_HLINE = 2'd1,
    OP_VLINE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic [15:0] COLOR_CLEAR  = 16'd0;
  localparam logic [15:0] COLOR_SET    = 16'd1;
  localparam logic [15:0] COLOR_INVERT = 16'd2;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture item, compute clipped run
    logic clear;   // reset sweep write of one byte
    logic rd;      // issue memory read at current address
    logic wr;      // write modified byte, advance
    logic finish;  // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;      // run draws nothing
    logic last;       // current byte is the last of the run
    logic is_read;    // item is a frame read
    logic clear_done; // last byte of reset sweep
  } stat_t;

endpackage

// ----- rtl/mono_page_framebuffer_draw.sv -----
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw
// 1-bit page-organized framebuffer drawing engine with rotation and clipping
// ----------------------------------------------------------------------------
// sequence: a read or an empty draw goes through load, check and done to the result;
// a draw does one read and one write per byte that it touches on the single-port
// frame memory. one item at a time.
// reset: rst clears rotation, then a sweep zeroes all WIDTH*ceil(HEIGHT/8)
// bytes of the frame (1024 with defaults) before the first item is taken.
module mono_page_framebuffer_draw #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], x_pos[17:2], y_pos[33:18], run_length[49:34],
  // color[65:50], byte_index[75:66], zero fill
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0]
  output logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  logic [1:0]      rotation;
  mpfd_pkg::cmd_t  cmd;
  mpfd_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      rotation <= cfg_data;
    end
  end

  mpfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mpfd_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rotation   (rotation),
    .operation  (s_tdata[1:0]),
    .x_pos      (s_tdata[17:2]),
    .y_pos      (s_tdata[33:18]),
    .run_length (s_tdata[49:34]),
    .color      (s_tdata[65:50]),
    .byte_index (s_tdata[75:66]),
    .cmd        (cmd),
    .stat       (stat),
    .read_data  (m_tdata)
  );

endmodule

// ----- rtl/mpfd_datapath.sv -----
// ----------------------------------------------------------------------------
// mpfd_datapath
// rotation, clipping, byte walk and read-modify-write of the frame memory
// ----------------------------------------------------------------------------
module mpfd_datapath #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic               clk,
  input  logic [1:0]         rotation,
  input  logic [1:0]         operation,
  input  logic signed [15:0] x_pos,
  input  logic signed [15:0] y_pos,
  input  logic signed [15:0] run_length,
  input  logic [15:0]        color,
  input  logic [9:0]         byte_index,
  input  mpfd_pkg::cmd_t     cmd,
  output mpfd_pkg::stat_t    stat,
  output logic [7:0]         read_data
);

  localparam int Pages      = (DISPLAY_HEIGHT + 7) / 8;
  localparam int FrameBytes = DISPLAY_WIDTH * Pages;
  localparam int Aw         = $clog2(FrameBytes);
  localparam int Cw         = 20;

  logic [7:0] mem [FrameBytes];
  logic [7:0] rdata;

  logic [Aw-1:0]   addr;
  logic [Aw-1:0]   last_addr;
  logic [Aw:0]     clr_cnt;
  logic            vert;
  logic            pix_mode;
  logic signed [Cw-1:0] y0;
  logic signed [Cw-1:0] y1;
  logic signed [Cw-1:0] pg_lo;
  logic [15:0]     color_q;
  logic            is_read;
  logic            rd_ok;
  logic            empty;
  logic [7:0]      read_res;

  // rotated run description
  logic            r_vert;
  logic signed [Cw-1:0] r_x;
  logic signed [Cw-1:0] r_y;
  logic signed [Cw-1:0] len;
  logic signed [Cw-1:0] wm;
  logic signed [Cw-1:0] hm;
  logic signed [Cw-1:0] xs;
  logic signed [Cw-1:0] ys;
  logic signed [Cw-1:0] lm1;
  logic signed [Cw-1:0] a0;
  logic signed [Cw-1:0] a1;
  logic signed [Cw-1:0] c0;
  logic signed [Cw-1:0] c1;
  logic            c_empty;
  logic signed [Cw-1:0] fix_max;
  logic signed [Cw-1:0] run_max;

  always_comb begin
    wm  = Cw'(DISPLAY_WIDTH - 1);
    hm  = Cw'(DISPLAY_HEIGHT - 1);
    xs  = Cw'(x_pos);
    ys  = Cw'(y_pos);
    len = Cw'(run_length);
    lm1 = len - Cw'(1);
    r_vert = 1'b0;
    r_x = xs;
    r_y = ys;
    if (operation == mpfd_pkg::OP_PIXEL) begin
      len = Cw'(1);
      lm1 = '0;
    end
    unique case (rotation)
      2'd0: begin
        r_vert = (operation == mpfd_pkg::OP_VLINE);
        r_x = xs;
        r_y = ys;
      end
      2'd1: begin
        r_vert = (operation != mpfd_pkg::OP_VLINE);
        r_x = (operation == mpfd_pkg::OP_VLINE) ? wm - ys - lm1 : wm - ys;
        r_y = xs;
      end
      2'd2: begin
        r_vert = (operation == mpfd_pkg::OP_VLINE);
        r_x = (operation == mpfd_pkg::OP_VLINE) ? wm - xs : wm - xs - lm1;
        r_y = (operation == mpfd_pkg::OP_VLINE) ? hm - ys - lm1 : hm - ys;
      end
      default: begin
        r_vert = (operation != mpfd_pkg::OP_VLINE);
        r_x = ys;
        r_y = (operation == mpfd_pkg::OP_VLINE) ? hm - xs : hm - xs - lm1;
      end
    endcase
    // run along one axis from a0 over len, fixed coordinate c0
    if (r_vert) begin
      a0 = r_y; c0 = r_x; fix_max = wm; run_max = hm;
    end else begin
      a0 = r_x; c0 = r_y; fix_max = hm; run_max = wm;
    end
    a1 = a0 + lm1;
    if (a0 < 0) a0 = '0;
    if (a1 > run_max) a1 = run_max;
    c1 = c0;
    c_empty = (c1 < 0) || (c1 > fix_max) || (len <= 0) || (a1 < a0)
              || (color > mpfd_pkg::COLOR_INVERT);
  end

  logic [Aw-1:0] start_addr;
  logic [Aw-1:0] end_addr;
  always_comb begin
    if (r_vert) begin
      start_addr = Aw'(c0[15:0]) + Aw'(a0[15:3]) * Aw'(DISPLAY_WIDTH);
      end_addr   = Aw'(c0[15:0]) + Aw'(a1[15:3]) * Aw'(DISPLAY_WIDTH);
    end else begin
      start_addr = Aw'(a0[15:0]) + Aw'(c0[15:3]) * Aw'(DISPLAY_WIDTH);
      end_addr   = Aw'(a1[15:0]) + Aw'(c0[15:3]) * Aw'(DISPLAY_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_read  <= (operation == mpfd_pkg::OP_READ);
      rd_ok    <= (int'(byte_index) < FrameBytes);
      empty    <= c_empty;
      vert     <= r_vert;
      color_q  <= color;
      if (operation == mpfd_pkg::OP_READ) begin
        addr <= Aw'(byte_index);
      end else begin
        addr <= start_addr;
      end
      last_addr <= end_addr;
      y0       <= r_vert ? a0 : c0;
      y1       <= r_vert ? a1 : c0;
      pg_lo    <= r_vert ? {a0[Cw-1:3], 3'b000} : {c0[Cw-1:3], 3'b000};
      pix_mode <= 1'b0;
    end else if (cmd.wr) begin
      addr  <= vert ? addr + Aw'(DISPLAY_WIDTH) : addr + Aw'(1);
      pg_lo <= vert ? pg_lo + Cw'(8) : pg_lo;
    end
  end

  // bit mask for the current byte
  logic [7:0] mask;
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b] = ((pg_lo + Cw'(b)) >= y0) && ((pg_lo + Cw'(b)) <= y1);
    end
  end

  logic [7:0] wdata;
  always_comb begin
    unique case (color_q[1:0])
      2'd0:    wdata = rdata & ~mask;
      2'd1:    wdata = rdata | mask;
      default: wdata = rdata ^ mask;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt[Aw-1:0]] <= '0;
    end else if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd.clear) begin
      clr_cnt <= '0;
    end else begin
      clr_cnt <= clr_cnt + (Aw+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_res <= (is_read && rd_ok) ? rdata : 8'd0;
    end
  end

  assign read_data = read_res;
  assign stat.empty      = empty;
  assign stat.last       = (addr == last_addr) || pix_mode;
  assign stat.is_read    = is_read;
  assign stat.clear_done = (clr_cnt == (Aw+1)'(FrameBytes - 1));

endmodule

// ----- rtl/mpfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpfd_ctrl
// sequencer: reset sweep, handshakes and read-modify-write per byte
// ----------------------------------------------------------------------------
module mpfd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic            cfg_ready,
  output mpfd_pkg::cmd_t  cmd,
  input  mpfd_pkg::stat_t stat
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;
  logic       out_valid_next;

  assign s_tready  = (state == S_IDLE) && !out_valid;
  assign m_tvalid  = out_valid;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !m_tready;
    cmd            = '0;
    unique case (state)
      S_CLEAR: begin
        // sweep counter holds at zero while reset is high
        cmd.clear = !rst;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_read) begin
          cmd.rd = 1'b1;
          state_next = S_DONE;
        end else if (stat.empty) begin
          state_next = S_DONE;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_WRITE;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        state_next = stat.last ? S_DONE : S_READ;
      end
      S_DONE: begin
        cmd.finish     = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
